// ===== hw/rtl/gmc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gmc_pkg;

    // Drive direction of the gate
    typedef enum logic [1:0] {
        MOT_STOPPED = 2'd0,
        MOT_OPENING = 2'd1,
        MOT_CLOSING = 2'd2
    } motion_t;

    // Control command codes
    localparam logic [7:0] CMD_STOP  = 8'd0;
    localparam logic [7:0] CMD_OPEN  = 8'd1;
    localparam logic [7:0] CMD_CLOSE = 8'd2;

    // Input word kinds
    localparam logic FUNC_TICK    = 1'b0;
    localparam logic FUNC_COMMAND = 1'b1;

    // Fault codes
    localparam logic [1:0] FAULT_NONE    = 2'd0;
    localparam logic [1:0] FAULT_TIMEOUT = 2'd1;
    localparam logic [1:0] FAULT_LIMITS  = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MOTOR_COUNT    = 3'd0,
        CFG_ACTIVE_HIGH    = 3'd1,
        CFG_TRAVEL_TIMEOUT = 3'd2,
        CFG_OPENED_FITTED  = 3'd3,
        CFG_CLOSED_FITTED  = 3'd4
    } cfg_index_t;

    // Timing
    localparam int unsigned INTERLOCK_W        = 10;
    localparam int unsigned TRAVEL_W           = 26;
    localparam int unsigned INTERLOCK_TICKS    = 250;
    localparam int unsigned MS_PER_S           = 1000;
    localparam int unsigned DEFAULT_TIMEOUT_MS = 60000;
    localparam logic [INTERLOCK_W-1:0] INTERLOCK_MAX = '1;
    localparam logic [TRAVEL_W-1:0]    TRAVEL_MAX    = '1;

    typedef struct packed {
        logic       func;
        logic [7:0] command;
        logic       opened_switch_level;
        logic       closed_switch_level;
    } in_t;

    typedef struct packed {
        logic       motor1_open_drive;
        logic       motor1_close_drive;
        logic       motor2_open_drive;
        logic       motor2_close_drive;
        logic [1:0] reported_motion;
        logic       busy_res;
        logic       opened_reached;
        logic       closed_reached;
        logic [1:0] fault_code;
        logic       cmd_status;
    } out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gate_motor_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Gate motor controller for one or two motors.
// Input channel (s_valid/s_ready/s_payload): each word is either a 1 ms tick or a control
// command (stop, open, close) together with the current levels of both limit switch pins.
// Result channel (m_valid/m_ready/m_payload): exactly one result word per input word, in
// order, carrying the drive pin levels, reported motion, busy flag, limit flags, fault code
// and whether the command was rejected.
// m_valid rises in the cycle after acceptance. Throughput: one word per cycle unless stalled;
// the whole update is a few compares and two counter increments, done in the cycle a word is taken.
// A single output register separates the channels: a new word is taken whenever that
// register is empty or is being emptied in the same cycle.
// Stall: while m_ready is low and a result is held, s_ready drops and the state holds.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata write one register per cycle, no wait.
// Writing the travel timeout stores it pre-scaled to milliseconds.
// Reset (aresetn low, synchronous): motors stopped, nothing pending, counters and fault
// cleared, registers at their defaults (one motor, active high outputs, 60 s travel limit,
// both limit switches fitted) and no result held.
module gate_motor_controller (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire gmc_pkg::in_t                       s_payload,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output gmc_pkg::out_t                           m_payload,
    input  wire logic                               cfg_wr_en,
    input  wire logic [gmc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [gmc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    // Configuration registers
    logic [1:0]                      motor_count_reg;
    logic                            active_high_reg;
    logic [gmc_pkg::TRAVEL_W-1:0]    timeout_ms_reg;
    logic                            opened_fitted_reg;
    logic                            closed_fitted_reg;
    logic [gmc_pkg::TRAVEL_W-1:0]    timeout_prod;

    // Controller state
    gmc_pkg::motion_t                motion_now_reg, motion_now_next;
    gmc_pkg::motion_t                motion_pending_reg, motion_pending_next;
    logic [gmc_pkg::INTERLOCK_W-1:0] interlock_reg, interlock_next, interlock_inc;
    logic [gmc_pkg::TRAVEL_W-1:0]    travel_reg, travel_next, travel_inc;
    logic [1:0]                      fault_reg, fault_next;

    // Result register
    logic                            m_valid_reg;
    gmc_pkg::out_t                   m_payload_reg, m_payload_next;

    logic                            accept;
    logic                            opened;
    logic                            closed;
    logic                            rejected;
    logic                            blocked;
    logic                            two_motors;
    logic                            drive_open;
    logic                            drive_close;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Limit is reached when the switch is fitted and its pin is pulled low
    assign opened = opened_fitted_reg && !s_payload.opened_switch_level;
    assign closed = closed_fitted_reg && !s_payload.closed_switch_level;

    // Scale the written timeout to milliseconds once, at write time
    assign timeout_prod = gmc_pkg::TRAVEL_W'(cfg_wdata)
                        * gmc_pkg::TRAVEL_W'(gmc_pkg::MS_PER_S);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            motor_count_reg   <= 2'd1;
            active_high_reg   <= 1'b1;
            timeout_ms_reg    <= gmc_pkg::TRAVEL_W'(gmc_pkg::DEFAULT_TIMEOUT_MS);
            opened_fitted_reg <= 1'b1;
            closed_fitted_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                gmc_pkg::CFG_MOTOR_COUNT: begin
                    motor_count_reg <= cfg_wdata[1:0];
                end
                gmc_pkg::CFG_ACTIVE_HIGH: begin
                    active_high_reg <= cfg_wdata[0];
                end
                gmc_pkg::CFG_TRAVEL_TIMEOUT: begin
                    // Zero selects the default 60 s limit
                    timeout_ms_reg <= (cfg_wdata == '0)
                                    ? gmc_pkg::TRAVEL_W'(gmc_pkg::DEFAULT_TIMEOUT_MS)
                                    : timeout_prod;
                end
                gmc_pkg::CFG_OPENED_FITTED: begin
                    opened_fitted_reg <= cfg_wdata[0];
                end
                gmc_pkg::CFG_CLOSED_FITTED: begin
                    closed_fitted_reg <= cfg_wdata[0];
                end
                default: begin
                    // Drop writes to unknown indexes
                end
            endcase
        end
    end

    // Saturating counter increments for a tick
    always_comb begin
        interlock_inc = interlock_reg;
        if (motion_pending_reg != gmc_pkg::MOT_STOPPED && interlock_reg != gmc_pkg::INTERLOCK_MAX)
            interlock_inc = interlock_reg + 1'b1;
        travel_inc = travel_reg;
        if (motion_now_reg != gmc_pkg::MOT_STOPPED && travel_reg != gmc_pkg::TRAVEL_MAX)
            travel_inc = travel_reg + 1'b1;
    end

    // Open request blocked at the opened limit, close at the closed limit
    assign blocked = (s_payload.command == gmc_pkg::CMD_OPEN && opened)
                  || (s_payload.command == gmc_pkg::CMD_CLOSE && closed);

    // Next state for one word
    always_comb begin
        motion_now_next     = motion_now_reg;
        motion_pending_next = motion_pending_reg;
        interlock_next      = interlock_reg;
        travel_next         = travel_reg;
        fault_next          = fault_reg;
        rejected            = 1'b0;

        if (s_payload.func == gmc_pkg::FUNC_COMMAND) begin
            if (s_payload.command > gmc_pkg::CMD_CLOSE) begin
                rejected = 1'b1;
            end else begin
                // Every valid command stops the motors first
                motion_now_next     = gmc_pkg::MOT_STOPPED;
                motion_pending_next = gmc_pkg::MOT_STOPPED;
                if (s_payload.command != gmc_pkg::CMD_STOP && !blocked) begin
                    motion_pending_next = gmc_pkg::motion_t'(s_payload.command[1:0]);
                    interlock_next      = '0;
                    fault_next          = gmc_pkg::FAULT_NONE;
                end
            end
        end else begin
            interlock_next = interlock_inc;
            travel_next    = travel_inc;
            if (opened && closed) begin
                fault_next          = gmc_pkg::FAULT_LIMITS;
                motion_now_next     = gmc_pkg::MOT_STOPPED;
                motion_pending_next = gmc_pkg::MOT_STOPPED;
            end else begin
                // Start the pending motion once the interlock time has run
                if (motion_pending_reg != gmc_pkg::MOT_STOPPED
                        && interlock_inc >= gmc_pkg::INTERLOCK_W'(gmc_pkg::INTERLOCK_TICKS)) begin
                    motion_now_next     = motion_pending_reg;
                    motion_pending_next = gmc_pkg::MOT_STOPPED;
                    travel_next         = '0;
                end
                priority if ((motion_now_next == gmc_pkg::MOT_OPENING && opened)
                        || (motion_now_next == gmc_pkg::MOT_CLOSING && closed)) begin
                    motion_now_next     = gmc_pkg::MOT_STOPPED;
                    motion_pending_next = gmc_pkg::MOT_STOPPED;
                end else if (motion_now_next != gmc_pkg::MOT_STOPPED
                        && travel_next >= timeout_ms_reg) begin
                    fault_next          = gmc_pkg::FAULT_TIMEOUT;
                    motion_now_next     = gmc_pkg::MOT_STOPPED;
                    motion_pending_next = gmc_pkg::MOT_STOPPED;
                end else begin
                    // Keep moving
                end
            end
        end
    end

    // Result word from the updated state; pins follow the current polarity
    assign two_motors  = motor_count_reg == 2'd2;
    assign drive_open  = motion_now_next == gmc_pkg::MOT_OPENING;
    assign drive_close = motion_now_next == gmc_pkg::MOT_CLOSING;

    always_comb begin
        m_payload_next.motor1_open_drive  = ~(drive_open ^ active_high_reg);
        m_payload_next.motor1_close_drive = ~(drive_close ^ active_high_reg);
        m_payload_next.motor2_open_drive  = ~((two_motors && drive_open) ^ active_high_reg);
        m_payload_next.motor2_close_drive = ~((two_motors && drive_close) ^ active_high_reg);
        m_payload_next.reported_motion    = (motion_pending_next != gmc_pkg::MOT_STOPPED)
                                          ? motion_pending_next : motion_now_next;
        m_payload_next.busy_res           = (motion_now_next != gmc_pkg::MOT_STOPPED)
                                         || (motion_pending_next != gmc_pkg::MOT_STOPPED);
        m_payload_next.opened_reached     = opened;
        m_payload_next.closed_reached     = closed;
        m_payload_next.fault_code         = fault_next;
        m_payload_next.cmd_status         = rejected;
    end

    // Advance state only on an accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            motion_now_reg     <= gmc_pkg::MOT_STOPPED;
            motion_pending_reg <= gmc_pkg::MOT_STOPPED;
            interlock_reg      <= '0;
            travel_reg         <= '0;
            fault_reg          <= gmc_pkg::FAULT_NONE;
        end else if (accept) begin
            motion_now_reg     <= motion_now_next;
            motion_pending_reg <= motion_pending_next;
            interlock_reg      <= interlock_next;
            travel_reg         <= travel_next;
            fault_reg          <= fault_next;
        end
    end

    // Output register: load on accept, clear valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_payload_reg <= m_payload_next;
        end
    end

`ifndef SYNTHESIS
    // A pending motion and a running motion never coexist
    a_motion_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(motion_now_reg != gmc_pkg::MOT_STOPPED
          && motion_pending_reg != gmc_pkg::MOT_STOPPED))
        else $error("motion running and pending at once");

    // Interlock count never passes the start threshold
    a_interlock_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        interlock_reg <= gmc_pkg::INTERLOCK_W'(gmc_pkg::INTERLOCK_TICKS))
        else $error("interlock count beyond threshold");

    // Busy flag agrees with reported motion
    a_busy_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_payload.busy_res == (m_payload.reported_motion != 2'd0)))
        else $error("busy flag disagrees with reported motion");

    // Held result is not overwritten while stalled
    a_stall_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !accept)
        else $error("word accepted while result stalled");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    import gmc_pkg::*;

    // Switch pin levels: the pins pull low when a limit is reached
    localparam logic LVL_FREE = 1'b1;
    localparam logic LVL_HIT  = 1'b0;

    // Command codes beyond the last valid one are rejected
    localparam logic [7:0] CMD_FIRST_BAD = 8'd3;
    localparam logic [7:0] CMD_LAST_BAD  = 8'hFF;

    // Register indexes past the end of the register list
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    // Watchdog: far above the slowest correct run under the heaviest stalls
    localparam int unsigned CYCLE_LIMIT = 100_000;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_t                    s_payload = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_t                   m_payload;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    always #5 aclk = ~aclk;

    gate_motor_controller i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Own copy of the controller: registers and gate state
    // ------------------------------------------------------------------
    logic [1:0]          cfg_motors;
    logic                cfg_act_hi;
    logic [15:0]         cfg_timeout_s;
    logic                cfg_open_fit;
    logic                cfg_close_fit;

    motion_t             mot_now;
    motion_t             mot_pend;
    logic [INTERLOCK_W-1:0] ilk_cnt;
    logic [TRAVEL_W-1:0]    trv_cnt;
    logic [1:0]          fault;

    // Drive words expected from the block, oldest first
    out_t                outputs_due[$];

    int unsigned         burst_left   = 0;
    int unsigned         sent_cnt     = 0;
    int unsigned         checked_cnt  = 0;
    int unsigned         mismatch_cnt = 0;
    int unsigned         orphan_cnt   = 0;
    int unsigned         cycle_cnt    = 0;

    // Receiver stall pattern state
    int unsigned         rx_mode      = 0;
    int unsigned         rx_mode_left = 0;

    task automatic clear_gate_state();
        cfg_motors    = 2'd1;
        cfg_act_hi    = 1'b1;
        cfg_timeout_s = '0;
        cfg_open_fit  = 1'b1;
        cfg_close_fit = 1'b1;
        mot_now       = MOT_STOPPED;
        mot_pend      = MOT_STOPPED;
        ilk_cnt       = '0;
        trv_cnt       = '0;
        fault         = FAULT_NONE;
    endtask

    // Pin level for an active or inactive drive under the current polarity
    function automatic logic pin_level(input logic active);
        return active == cfg_act_hi;
    endfunction

    // Advance the gate state by one word and return the drive word it yields
    function automatic out_t step_gate(input in_t w);
        out_t        r;
        logic        at_open;
        logic        at_close;
        logic        two;
        logic [31:0] limit_ms;
        r        = '0;
        at_open  = cfg_open_fit && (w.opened_switch_level == LVL_HIT);
        at_close = cfg_close_fit && (w.closed_switch_level == LVL_HIT);
        if (w.func == FUNC_COMMAND) begin
            if (w.command > CMD_CLOSE) begin
                r.cmd_status = 1'b1;
            end else begin
                // any valid command stops first
                mot_now  = MOT_STOPPED;
                mot_pend = MOT_STOPPED;
                if ((w.command == CMD_OPEN && !at_open) ||
                    (w.command == CMD_CLOSE && !at_close)) begin
                    mot_pend = motion_t'(w.command[1:0]);
                    ilk_cnt  = '0;
                    fault    = FAULT_NONE;
                end
            end
        end else begin
            if (mot_pend != MOT_STOPPED && ilk_cnt != INTERLOCK_MAX) ilk_cnt++;
            if (mot_now != MOT_STOPPED && trv_cnt != TRAVEL_MAX) trv_cnt++;
            if (at_open && at_close) begin
                fault    = FAULT_LIMITS;
                mot_now  = MOT_STOPPED;
                mot_pend = MOT_STOPPED;
            end else begin
                if (mot_pend != MOT_STOPPED && ilk_cnt >= INTERLOCK_TICKS) begin
                    mot_now  = mot_pend;
                    mot_pend = MOT_STOPPED;
                    trv_cnt  = '0;
                end
                limit_ms = cfg_timeout_s * MS_PER_S;
                if (limit_ms == 0) limit_ms = DEFAULT_TIMEOUT_MS;
                if ((mot_now == MOT_OPENING && at_open) ||
                    (mot_now == MOT_CLOSING && at_close)) begin
                    mot_now  = MOT_STOPPED;
                    mot_pend = MOT_STOPPED;
                end else if (mot_now != MOT_STOPPED && trv_cnt >= limit_ms) begin
                    fault    = FAULT_TIMEOUT;
                    mot_now  = MOT_STOPPED;
                    mot_pend = MOT_STOPPED;
                end
            end
        end
        two                  = (cfg_motors == 2'd2);
        r.motor1_open_drive  = pin_level(mot_now == MOT_OPENING);
        r.motor1_close_drive = pin_level(mot_now == MOT_CLOSING);
        r.motor2_open_drive  = pin_level(two && mot_now == MOT_OPENING);
        r.motor2_close_drive = pin_level(two && mot_now == MOT_CLOSING);
        r.reported_motion    = (mot_pend != MOT_STOPPED) ? mot_pend : mot_now;
        r.busy_res           = (mot_now != MOT_STOPPED) || (mot_pend != MOT_STOPPED);
        r.opened_reached     = at_open;
        r.closed_reached     = at_close;
        r.fault_code         = fault;
        return r;
    endfunction

    function automatic in_t mk(input logic f, input logic [7:0] c,
                               input logic ol, input logic cl);
        in_t w;
        w.func                = f;
        w.command             = c;
        w.opened_switch_level = ol;
        w.closed_switch_level = cl;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Sender: bursts of random length with random gaps in between
    // ------------------------------------------------------------------
    task automatic send_word(input in_t w);
        int unsigned gap;
        if (burst_left == 0) begin
            // now and then a long stretch with no idling at all
            if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(40, 120);
            else burst_left = $urandom_range(1, 8);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_payload <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // accepted at this edge: predict now, in order
        outputs_due.push_back(step_gate(w));
        sent_cnt++;
    endtask

    // Ticks with inactive switches; a shaken pin takes random levels
    task automatic send_ticks(input int unsigned n, input logic shake_open,
                              input logic shake_close);
        in_t w;
        for (int unsigned i = 0; i < n; i++) begin
            w = mk(FUNC_TICK, 8'($urandom_range(0, 255)),
                   shake_open ? ($urandom_range(0, 1) != 0) : LVL_FREE,
                   shake_close ? ($urandom_range(0, 1) != 0) : LVL_FREE);
            send_word(w);
        end
    endtask

    // Drop valid, hold until every drive word is back, then let the pipe settle
    task automatic wait_idle();
        s_valid    <= 1'b0;
        burst_left  = 0;
        while (outputs_due.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            CFG_MOTOR_COUNT:    cfg_motors    = data[1:0];
            CFG_ACTIVE_HIGH:    cfg_act_hi    = data[0];
            CFG_TRAVEL_TIMEOUT: cfg_timeout_s = data;
            CFG_OPENED_FITTED:  cfg_open_fit  = data[0];
            CFG_CLOSED_FITTED:  cfg_close_fit = data[0];
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [15:0] motors, input logic [15:0] act_hi,
                              input logic [15:0] timeout_s, input logic [15:0] open_fit,
                              input logic [15:0] close_fit);
        wait_idle();
        write_reg(CFG_MOTOR_COUNT, motors);
        write_reg(CFG_ACTIVE_HIGH, act_hi);
        write_reg(CFG_TRAVEL_TIMEOUT, timeout_s);
        write_reg(CFG_OPENED_FITTED, open_fit);
        write_reg(CFG_CLOSED_FITTED, close_fit);
    endtask

    // ------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------

    // Command decoding, rejected requests, the both-limits fault and fault clearing
    task automatic test_commands();
        send_word(mk(FUNC_COMMAND, CMD_LAST_BAD, LVL_FREE, LVL_FREE));
        send_word(mk(FUNC_COMMAND, CMD_FIRST_BAD, LVL_FREE, LVL_FREE));
        send_word(mk(FUNC_COMMAND, 8'($urandom_range(CMD_FIRST_BAD, CMD_LAST_BAD)),
                     LVL_HIT, LVL_HIT));
        send_word(mk(FUNC_COMMAND, CMD_STOP, LVL_FREE, LVL_FREE));
        // request towards a limit already reached: dropped
        send_word(mk(FUNC_COMMAND, CMD_OPEN, LVL_HIT, LVL_FREE));
        send_word(mk(FUNC_COMMAND, CMD_CLOSE, LVL_FREE, LVL_HIT));
        send_word(mk(FUNC_COMMAND, CMD_CLOSE, LVL_FREE, LVL_FREE));
        // a bad command must leave the pending close alone
        send_word(mk(FUNC_COMMAND, 8'($urandom_range(CMD_FIRST_BAD, CMD_LAST_BAD)),
                     LVL_FREE, LVL_FREE));
        send_word(mk(FUNC_TICK, CMD_STOP, LVL_FREE, LVL_FREE));
        // both limits on a tick: fault and stop
        send_word(mk(FUNC_TICK, CMD_STOP, LVL_HIT, LVL_HIT));
        // stop and a dropped request keep the fault
        send_word(mk(FUNC_COMMAND, CMD_STOP, LVL_HIT, LVL_HIT));
        send_word(mk(FUNC_COMMAND, CMD_OPEN, LVL_HIT, LVL_HIT));
        send_word(mk(FUNC_COMMAND, CMD_OPEN, LVL_FREE, LVL_FREE));
        send_word(mk(FUNC_TICK, CMD_CLOSE, LVL_HIT, LVL_FREE));
        send_word(mk(FUNC_COMMAND, CMD_STOP, LVL_FREE, LVL_FREE));
        send_word(mk(FUNC_TICK, CMD_LAST_BAD, LVL_FREE, LVL_FREE));
        send_word(mk(FUNC_COMMAND, CMD_CLOSE, LVL_FREE, LVL_HIT));
        send_word(mk(FUNC_TICK, CMD_OPEN, LVL_FREE, LVL_HIT));
        send_word(mk(FUNC_COMMAND, CMD_OPEN, LVL_FREE, LVL_FREE));
        send_word(mk(FUNC_COMMAND, CMD_CLOSE, LVL_FREE, LVL_FREE));
        send_word(mk(FUNC_COMMAND, CMD_STOP, LVL_FREE, LVL_FREE));
        send_word(in_t'('1));
        send_word(in_t'('0));
    endtask

    // Writes beyond the register list must change nothing
    task automatic test_spare_registers();
        wait_idle();
        for (logic [CFG_INDEX_W:0] i = CFG_SPARE_FIRST; i <= CFG_SPARE_LAST; i++) begin
            write_reg(i[CFG_INDEX_W-1:0], 16'h0000);
            write_reg(i[CFG_INDEX_W-1:0], 16'hFFFF);
        end
        send_word(mk(FUNC_COMMAND, CMD_OPEN, LVL_FREE, LVL_FREE));
        send_ticks(4, 1'b0, 1'b1);
        send_word(mk(FUNC_COMMAND, CMD_STOP, LVL_FREE, LVL_FREE));
    endtask

    // Interlock start, stop at the limit, retargeting and live config changes
    task automatic test_limit_stops();
        set_config(16'd2, 16'd1, 16'd0, 16'd1, 16'd1);
        send_word(mk(FUNC_COMMAND, CMD_OPEN, LVL_FREE, LVL_FREE));
        send_ticks(INTERLOCK_TICKS + 2, 1'b0, 1'b0);
        // polarity and motor count follow at once, even mid-travel
        wait_idle();
        write_reg(CFG_ACTIVE_HIGH, 16'd0);
        send_ticks(3, 1'b0, 1'b0);
        wait_idle();
        write_reg(CFG_MOTOR_COUNT, 16'd1);
        send_ticks(3, 1'b0, 1'b0);
        wait_idle();
        write_reg(CFG_MOTOR_COUNT, 16'd2);
        // the closed limit does not stop an opening gate
        send_word(mk(FUNC_TICK, CMD_STOP, LVL_FREE, LVL_HIT));
        // run into the opened limit
        send_word(mk(FUNC_TICK, CMD_STOP, LVL_HIT, LVL_FREE));
        // close from the opened end, then retarget before it starts
        send_word(mk(FUNC_COMMAND, CMD_CLOSE, LVL_HIT, LVL_FREE));
        send_ticks(5, 1'b1, 1'b0);
        send_word(mk(FUNC_COMMAND, CMD_OPEN, LVL_FREE, LVL_FREE));
        // both limits while a motion pends
        send_word(mk(FUNC_TICK, CMD_STOP, LVL_HIT, LVL_HIT));
        send_word(mk(FUNC_COMMAND, CMD_STOP, LVL_FREE, LVL_FREE));
    endtask

    // Upper data bits set: only the register width may be taken
    task automatic test_config_masking();
        set_config(16'hFFFF, 16'hFFFE, 16'hFFFF, 16'hFFFF, 16'h0003);
        send_word(mk(FUNC_COMMAND, CMD_CLOSE, LVL_FREE, LVL_FREE));
        send_ticks(6, 1'b1, 1'b1);
        send_word(mk(FUNC_COMMAND, CMD_OPEN, LVL_FREE, LVL_FREE));
        send_ticks(6, 1'b1, 1'b1);
        send_word(mk(FUNC_COMMAND, CMD_STOP, LVL_FREE, LVL_FREE));
    endtask

    // Short request-and-tick sequences, some short mixes and noise
    task automatic run_random(input int unsigned n_items);
        int unsigned done_cnt;
        int unsigned kind;
        int unsigned len;
        done_cnt = 0;
        while (done_cnt < n_items) begin
            kind = $urandom_range(0, 9);
            if (kind < 5) begin
                send_word(mk(FUNC_COMMAND, 8'($urandom_range(CMD_OPEN, CMD_CLOSE)),
                             $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0));
                len = $urandom_range(1, 20);
                send_ticks(len, 1'b0, 1'b0);
                // random pins at the end: limit stop, fault or nothing
                send_ticks($urandom_range(1, 6), 1'b1, 1'b1);
                done_cnt += len + 4;
            end else if (kind < 8) begin
                len = $urandom_range(1, 8);
                for (int unsigned i = 0; i < len; i++) begin
                    if ($urandom_range(0, 1) != 0)
                        send_word(mk(FUNC_COMMAND,
                                     8'($urandom_range(CMD_STOP, CMD_CLOSE + 1)),
                                     $urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0));
                    else
                        send_ticks(1, 1'b1, 1'b1);
                end
                done_cnt += len;
            end else begin
                len = $urandom_range(1, 4);
                for (int unsigned i = 0; i < len; i++) send_word(in_t'($urandom));
                done_cnt += len;
            end
        end
    endtask

    task automatic test_random_traffic();
        set_config(16'd2, 16'd0, 16'd0, 16'd1, 16'd1);
        run_random(40);
        // hold the sender until the pipe has drained
        wait_idle();
        run_random(30);
        set_config(16'd1, 16'd1, 16'd2, 16'd0, 16'd1);
        run_random(30);
        set_config(16'd0, 16'd1, 16'hFFFF, 16'd1, 16'd0);
        run_random(30);
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall on a pattern that changes mode every so often
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode      <= $urandom_range(0, 3);
            rx_mode_left <= $urandom_range(20, 200);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 1) != 0);
            2:       m_ready <= ($urandom_range(0, 3) != 0);
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // ------------------------------------------------------------------
    // Result check: every drive word against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (outputs_due.size() == 0) begin
                orphan_cnt++;
                if (orphan_cnt + mismatch_cnt <= 10)
                    $display("unexpected drive word %h with nothing due", m_payload);
            end else begin
                want = outputs_due.pop_front();
                checked_cnt++;
                if (m_payload !== want) begin
                    mismatch_cnt++;
                    if (mismatch_cnt + orphan_cnt <= 10)
                        $display({"word %0d: drives m1o/m1c/m2o/m2c exp %b%b%b%b got %b%b%b%b,",
                                  " motion exp %0d got %0d, busy exp %b got %b,",
                                  " reached o/c exp %b%b got %b%b, fault exp %0d got %0d,",
                                  " rejected exp %b got %b"},
                                 checked_cnt,
                                 want.motor1_open_drive, want.motor1_close_drive,
                                 want.motor2_open_drive, want.motor2_close_drive,
                                 m_payload.motor1_open_drive, m_payload.motor1_close_drive,
                                 m_payload.motor2_open_drive, m_payload.motor2_close_drive,
                                 want.reported_motion, m_payload.reported_motion,
                                 want.busy_res, m_payload.busy_res,
                                 want.opened_reached, want.closed_reached,
                                 m_payload.opened_reached, m_payload.closed_reached,
                                 want.fault_code, m_payload.fault_code,
                                 want.cmd_status, m_payload.cmd_status);
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still due",
                     cycle_cnt, outputs_due.size());
            $display("gate_motor_controller regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset once, then each test in turn
    // ------------------------------------------------------------------
    initial begin
        clear_gate_state();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_commands();
        test_spare_registers();
        test_limit_stops();
        test_config_masking();
        test_random_traffic();

        // drain, then give any stray word time to show up
        wait_idle();
        repeat (5) @(posedge aclk);

        $display("%0d words sent, %0d drive words checked, %0d wrong, %0d unexpected, %0d due",
                 sent_cnt, checked_cnt, mismatch_cnt, orphan_cnt, outputs_due.size());
        $display("covered: commands, interlock start, limit stops, both-limits fault,");
        $display("         live polarity and motor count changes, register masking");
        if (mismatch_cnt == 0 && orphan_cnt == 0 && outputs_due.size() == 0) begin
            $display("gate_motor_controller regression: pass");
        end else begin
            $display("gate_motor_controller regression: fail");
        end
        $finish;
    end

endmodule
